[hw/rtl/key_value_table_defines.svh]
// assertion helpers for the key/value table
`ifndef KEY_VALUE_TABLE_DEFINES_SVH
`define KEY_VALUE_TABLE_DEFINES_SVH

// same-cycle check: when ante holds, cons holds in that cycle
`define KVT_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle check: when ante holds, cons holds in the next cycle
`define KVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/kvt_pkg.sv]
package kvt_pkg;

  // default sizing
  localparam int KVT_ENTRIES    = 16;
  localparam int KVT_KEY_BITS   = 32;
  localparam int KVT_VALUE_BITS = 32;

  // beat field widths
  localparam int FUNC_BITS    = 2;
  localparam int KEY_W        = 32;
  localparam int VALUE_W      = 32;
  localparam int ENTRIES_W    = 5;
  localparam int IN_DATA_W    = KEY_W + VALUE_W;
  localparam int OUT_FIELDS_W = 1 + VALUE_W + 1 + ENTRIES_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // operation codes
  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_GET    = 2'd2
  } func_t;

endpackage

[hw/rtl/key_value_table.sv]
// Bounded table of unique key/value pairs. Each input beat carries one operation in
// s_axis_tuser (add, remove or get) and the key and value in s_axis_tdata; each one
// returns exactly one result beat with the hit and refused flags, the looked-up value
// and the pair count after the operation. Keys and the slot valid bits sit in one
// single-port-read memory, values in a second one. Every operation scans all ENTRIES
// slots through the key memory's read port, one slot per cycle. The result beat is
// built through the scan, update and done states, and a new beat is taken only once
// the last result is loaded into the output register; the next beat is taken while
// the previous result still waits on the output. After reset the block clears the
// valid bits of every slot and holds s_axis_tready low.
`include "key_value_table_defines.svh"

module key_value_table #(
  parameter int ENTRIES    = kvt_pkg::KVT_ENTRIES,
  parameter int KEY_BITS   = kvt_pkg::KVT_KEY_BITS,
  parameter int VALUE_BITS = kvt_pkg::KVT_VALUE_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // key [31:0], value [63:32]
  input  logic [kvt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // func [1:0]
  input  logic [kvt_pkg::FUNC_BITS-1:0]   s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // hit [0], value_out [32:1], refused [33], entries [38:34], zero fill [39]
  output logic [kvt_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import kvt_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int TW = KEY_BITS + 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(ENTRIES - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_DONE
  } state_t;

  state_t state;

  // tag memory: valid bit on top of the key
  logic [TW-1:0]         tag_mem [ENTRIES];
  logic [VALUE_BITS-1:0] val_mem [ENTRIES];

  logic [TW-1:0]         tag_q;
  logic [VALUE_BITS-1:0] val_q;

  logic                  tag_re;
  logic                  tag_we;
  logic [AW-1:0]         tag_waddr;
  logic [TW-1:0]         tag_wdata;
  logic                  val_re;
  logic                  val_we;

  // operation and scan registers
  logic [AW-1:0]         addr;
  logic                  issue_done;
  logic                  rd_valid;
  logic                  rd_last;
  logic [AW-1:0]         rd_slot;
  logic [FUNC_BITS-1:0]  op;
  logic [KEY_BITS-1:0]   op_key;
  logic [VALUE_BITS-1:0] op_value;
  logic                  found;
  logic [AW-1:0]         match_slot;
  logic                  free_found;
  logic [AW-1:0]         free_slot;
  logic [CW-1:0]         count;
  logic                  res_hit;
  logic                  res_refused;
  logic                  res_get;
  logic                  tag_hit;

  assign s_axis_tready = (state == ST_IDLE);
  assign tag_hit = tag_q[KEY_BITS] && (tag_q[KEY_BITS-1:0] == op_key);

  // memory port control
  always_comb begin
    tag_re    = (state == ST_SCAN) && !issue_done;
    val_re    = (state == ST_UPDATE);
    tag_we    = 1'b0;
    tag_waddr = addr;
    tag_wdata = '0;
    val_we    = 1'b0;
    case (state)
      ST_CLEAR: begin
        tag_we = 1'b1;
      end
      ST_UPDATE: begin
        if (op == FUNC_ADD && !found && free_found) begin
          tag_we    = 1'b1;
          tag_waddr = free_slot;
          tag_wdata = {1'b1, op_key};
          val_we    = 1'b1;
        end else if (op == FUNC_REMOVE && found) begin
          tag_we    = 1'b1;
          tag_waddr = match_slot;
          tag_wdata = {1'b0, op_key};
        end
      end
      default: begin
      end
    endcase
  end

  // key/valid memory
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_waddr] <= tag_wdata;
    end
    if (tag_re) begin
      tag_q <= tag_mem[addr];
    end
  end

  // value memory
  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[free_slot] <= op_value;
    end
    if (val_re) begin
      val_q <= val_mem[match_slot];
    end
  end

  // sequencer with output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      addr          <= '0;
      issue_done    <= 1'b0;
      rd_valid      <= 1'b0;
      rd_last       <= 1'b0;
      found         <= 1'b0;
      free_found    <= 1'b0;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      rd_valid <= tag_re;
      rd_last  <= tag_re && (addr == LAST_SLOT);
      if (tag_re) begin
        rd_slot <= addr;
      end
      // result beat taken and no new one loaded this cycle
      if (m_axis_tvalid && m_axis_tready && state != ST_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        // sweep the valid bits after reset
        ST_CLEAR: begin
          if (addr == LAST_SLOT) begin
            addr  <= '0;
            state <= ST_IDLE;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        // take one operation beat
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            op         <= s_axis_tuser;
            op_key     <= KEY_BITS'(s_axis_tdata[KEY_W-1:0]);
            op_value   <= VALUE_BITS'(s_axis_tdata[IN_DATA_W-1:KEY_W]);
            found      <= 1'b0;
            free_found <= 1'b0;
            addr       <= '0;
            issue_done <= 1'b0;
            state      <= ST_SCAN;
          end
        end
        // read every slot, note the match and the lowest free slot
        ST_SCAN: begin
          if (!issue_done) begin
            if (addr == LAST_SLOT) begin
              addr       <= '0;
              issue_done <= 1'b1;
            end else begin
              addr <= addr + 1'b1;
            end
          end
          if (rd_valid) begin
            if (tag_hit && !found) begin
              found      <= 1'b1;
              match_slot <= rd_slot;
            end
            if (!tag_q[KEY_BITS] && !free_found) begin
              free_found <= 1'b1;
              free_slot  <= rd_slot;
            end
            if (rd_last) begin
              state <= ST_UPDATE;
            end
          end
        end
        // write back and settle the flags
        ST_UPDATE: begin
          res_hit     <= found && (op == FUNC_ADD || op == FUNC_REMOVE || op == FUNC_GET);
          res_refused <= (op == FUNC_ADD) && !found && !free_found;
          res_get     <= (op == FUNC_GET) && found;
          if (op == FUNC_ADD && !found && free_found) begin
            count <= count + 1'b1;
          end else if (op == FUNC_REMOVE && found) begin
            count <= count - 1'b1;
          end
          state <= ST_DONE;
        end
        // load the result beat once the output register is free
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= OUT_DATA_W'({
              ENTRIES_W'(count),
              res_refused,
              res_get ? VALUE_W'(val_q) : {VALUE_W{1'b0}},
              res_hit
            });
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  `KVT_ASSERT(a_count_bound, 1'b1, count <= FULL_COUNT, "pair count above table size")
  `KVT_ASSERT(a_no_take_in_clear, state == ST_CLEAR, !s_axis_tready,
              "beat taken during the clearing sweep")
  `KVT_ASSERT(a_refuse_when_full,
              state == ST_UPDATE && op == FUNC_ADD && !found && !free_found,
              count == FULL_COUNT, "add refused while the count shows a free slot")
  `KVT_ASSERT(a_flags_exclusive, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[VALUE_W + 1]),
              "result shows both hit and refused")
  `KVT_ASSERT_NEXT(a_remove_count, state == ST_UPDATE && op == FUNC_REMOVE && found,
                   count == CW'($past(count) - 1'b1), "remove hit did not drop the count")

endmodule
